[rtl/srs_pkg.sv]
// Package for the stripe request splitter.
// Holds the payload structs, the controller state and command types and the constants.
// No dependencies.
package srs_pkg;

  localparam int unsigned StripeBytes = 8192;
  localparam int unsigned StripeBits  = 13;
  localparam int unsigned MaxDevices  = 256;
  localparam int unsigned MaxChunks   = 64;

  localparam int unsigned OffW     = 48;
  localparam int unsigned LenW     = 19;
  localparam int unsigned StripeW  = OffW - StripeBits;
  localparam int unsigned DevW     = 8;
  localparam int unsigned NumDevW  = 9;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned ChunkW   = 14;
  localparam int unsigned SecCntW  = 5;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned StepW    = 6;

  localparam logic [LenW-1:0]    MaxLen    = LenW'((MaxChunks - 1) * StripeBytes);
  localparam logic [StepW-1:0]   DivSteps  = StepW'(StripeW);
  localparam logic [ShiftW-1:0]  ShiftMin  = 4'd9;
  localparam logic [ShiftW-1:0]  ShiftMax  = 4'd12;
  localparam logic [NumDevW-1:0] DevMaxCnt = NumDevW'(MaxDevices);

  typedef enum logic {
    CfgNumDevices  = 1'b0,
    CfgSectorShift = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StDivide = 2'd1,
    StEmit   = 2'd2,
    StError  = 2'd3
  } srs_state_e;

  typedef struct packed {
    logic            cmd;
    logic [OffW-1:0] request_offset;
    logic [LenW-1:0] request_length;
  } req_t;

  typedef struct packed {
    logic [DevW-1:0]    device_index;
    logic [OffW-1:0]    device_offset;
    logic [ChunkW-1:0]  chunk_length;
    logic [OffW-1:0]    sector_start;
    logic [SecCntW-1:0] sector_count;
    logic               is_write;
    logic               error;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic emit_chunk;
    logic emit_error;
  } srs_cmd_t;

  typedef struct packed {
    logic req_zero;
    logic req_overlong;
    logic div_done;
    logic chunk_last;
    logic out_free;
  } srs_status_t;

endpackage

[rtl/srs_ctrl.sv]
// Controller state machine of the stripe request splitter.
// Sequences request capture, the device count division, chunk emission and error results.
// Depends on srs_pkg.
module srs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srs_pkg::srs_status_t status_i,
  output srs_pkg::srs_cmd_t    cmd_o
);
  import srs_pkg::*;

  srs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (status_i.req_zero) begin
            state_d = StIdle;
          end else if (status_i.req_overlong) begin
            state_d = StError;
          end else begin
            state_d = StDivide;
          end
        end
      end
      StDivide: begin
        if (status_i.div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free && status_i.chunk_last) begin
          state_d = StIdle;
        end
      end
      StError: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      StDivide: begin
        cmd_o.div_step = !status_i.div_done;
      end
      StEmit: begin
        cmd_o.emit_chunk = status_i.out_free;
      end
      StError: begin
        cmd_o.emit_error = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/srs_dp.sv]
// Datapath of the stripe request splitter: request registers, the serial
// divider that doubles as the device and block counter, chunk math and the output register.
// Depends on srs_pkg.
module srs_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srs_pkg::req_t                in_data_i,
  input  logic [srs_pkg::NumDevW-1:0]  num_dev_i,
  input  logic [srs_pkg::ShiftW-1:0]   shift_i,
  input  srs_pkg::srs_cmd_t            cmd_i,
  output srs_pkg::srs_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output srs_pkg::rsp_t                out_data_o
);
  import srs_pkg::*;

  logic                  wr_q, wr_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [StripeBits-1:0] within_q, within_d;
  logic [NumDevW-1:0]    n_q, n_d;
  logic [ShiftW-1:0]     sh_q, sh_d;
  logic [StripeW-1:0]    quo_q, quo_d;
  logic                  quo_hi_q, quo_hi_d;
  logic [NumDevW-1:0]    rem_q, rem_d;
  logic [StepW-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  logic [NumDevW:0]      trial;
  logic [ChunkW-1:0]     room;
  logic                  chunk_last;
  logic [ChunkW-1:0]     chunk_len;
  logic [StripeBits-1:0] sec_m1;
  logic [14:0]           end_sum;
  logic [14:0]           end_sec;
  logic [14:0]           first_sec;
  logic [OffW-1:0]       doff;
  logic [OffW:0]         doff_full;
  logic [OffW:0]         sec_full;
  logic [NumDevW-1:0]    dev_next;
  logic                  out_free;

  assign trial      = {rem_q, quo_q[StripeW-1]} - {1'b0, n_q};
  assign room       = ChunkW'(StripeBytes) - {1'b0, within_q};
  assign chunk_last = len_q <= LenW'(room);
  assign chunk_len  = chunk_last ? len_q[ChunkW-1:0] : room;
  assign sec_m1     = (StripeBits'(1) << sh_q) - StripeBits'(1);
  assign end_sum    = 15'(within_q) + 15'(chunk_len) + 15'(sec_m1);
  assign end_sec    = end_sum >> sh_q;
  assign first_sec  = 15'(within_q >> sh_q);
  assign doff       = {quo_q, within_q};
  assign doff_full  = {quo_hi_q, quo_q, within_q};
  assign sec_full   = doff_full >> sh_q;
  assign dev_next   = rem_q + NumDevW'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    wr_d     = wr_q;
    len_d    = len_q;
    within_d = within_q;
    n_d      = n_q;
    sh_d     = sh_q;
    quo_d    = quo_q;
    quo_hi_d = quo_hi_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    if (cmd_i.start) begin
      wr_d     = in_data_i.cmd;
      len_d    = in_data_i.request_length;
      within_d = in_data_i.request_offset[StripeBits-1:0];
      quo_d    = in_data_i.request_offset[OffW-1:StripeBits];
      quo_hi_d = 1'b0;
      rem_d    = '0;
      cnt_d    = '0;
      n_d      = num_dev_i;
      sh_d     = shift_i;
    end else if (cmd_i.div_step) begin
      cnt_d = cnt_q + StepW'(1);
      if (!trial[NumDevW]) begin
        rem_d = trial[NumDevW-1:0];
        quo_d = {quo_q[StripeW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[NumDevW-2:0], quo_q[StripeW-1]};
        quo_d = {quo_q[StripeW-2:0], 1'b0};
      end
    end else if (cmd_i.emit_chunk) begin
      len_d    = len_q - LenW'(chunk_len);
      within_d = '0;
      if (dev_next == n_q) begin
        rem_d               = '0;
        {quo_hi_d, quo_d}   = {quo_hi_q, quo_q} + {{StripeW{1'b0}}, 1'b1};
      end else begin
        rem_d = dev_next;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_chunk) begin
      out_valid_d         = 1'b1;
      out_d.device_index  = rem_q[DevW-1:0];
      out_d.device_offset = doff;
      out_d.chunk_length  = chunk_len;
      out_d.sector_start  = sec_full[OffW-1:0];
      out_d.sector_count  = SecCntW'(end_sec - first_sec);
      out_d.is_write      = wr_q;
      out_d.error         = 1'b0;
      out_d.last          = chunk_last;
    end else if (cmd_i.emit_error) begin
      out_valid_d    = 1'b1;
      out_d          = '0;
      out_d.is_write = wr_q;
      out_d.error    = 1'b1;
      out_d.last     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    len_q    <= len_d;
    within_q <= within_d;
    n_q      <= n_d;
    sh_q     <= sh_d;
    quo_q    <= quo_d;
    quo_hi_q <= quo_hi_d;
    rem_q    <= rem_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.req_zero     = in_data_i.request_length == '0;
  assign status_o.req_overlong = in_data_i.request_length > MaxLen;
  assign status_o.div_done     = cnt_q == DivSteps;
  assign status_o.chunk_last   = chunk_last;
  assign status_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_chunk || cmd_i.emit_error) |-> out_free)
    else $error("Output register loaded while a result is still pending.");

  a_emit_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_chunk |-> (cnt_q == DivSteps))
    else $error("Chunk emitted before the division finished.");

  a_dev_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_chunk |-> (rem_q < n_q))
    else $error("Device index not below the device count.");

  a_chunk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_chunk |-> (chunk_len != '0))
    else $error("Empty chunk emitted.");

endmodule

[rtl/stripe_request_splitter_top.sv]
// Each accepted request is captured, passes through the one-bit-per-cycle divider that finds
// the first stripe's device and device block, and then yields one chunk per cycle (at most 64)
// whenever the output register is free; a zero-length request is done at capture and an
// overlong one yields its error result as soon as the output register is free after capture.
// The next request is taken once the last result of the current one is in the output register.
// Top level of the stripe request splitter: configuration registers, controller and datapath.
// Depends on srs_pkg, srs_ctrl and srs_dp.
module stripe_request_splitter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [srs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srs_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output srs_pkg::rsp_t                 out_data_o
);
  import srs_pkg::*;

  logic [NumDevW-1:0] num_dev_q, num_dev_d;
  logic [ShiftW-1:0]  shift_q, shift_d;
  logic [NumDevW-1:0] num_dev_eff;
  logic [ShiftW-1:0]  shift_eff;
  cfg_reg_e           cfg_idx;
  srs_cmd_t           cmd;
  srs_status_t        status;

  assign cfg_idx = cfg_reg_e'(cfg_idx_i);

  always_comb begin
    num_dev_d = num_dev_q;
    shift_d   = shift_q;
    if (cfg_we_i) begin
      case (cfg_idx)
        CfgNumDevices:  num_dev_d = cfg_wdata_i;
        CfgSectorShift: shift_d   = cfg_wdata_i[ShiftW-1:0];
        default: begin
          num_dev_d = num_dev_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dev_q <= NumDevW'(1);
      shift_q   <= ShiftMin;
    end else begin
      num_dev_q <= num_dev_d;
      shift_q   <= shift_d;
    end
  end

  assign num_dev_eff = (num_dev_q == '0) ? NumDevW'(1) :
                       (num_dev_q > DevMaxCnt) ? DevMaxCnt : num_dev_q;
  assign shift_eff   = (shift_q < ShiftMin) ? ShiftMin :
                       (shift_q > ShiftMax) ? ShiftMax : shift_q;

  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .num_dev_i   (num_dev_eff),
    .shift_i     (shift_eff),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/sv/stripe_request_splitter_top_tb.sv]
// Testbench for stripe_request_splitter_top: directed and random requests with a self-checking
// chunk predictor, random stalls on both channels and several register settings.
// Depends on srs_pkg and the stripe_request_splitter_top RTL.
`timescale 1ns / 100ps

module stripe_request_splitter_top_tb;
  import srs_pkg::*;

  localparam int unsigned DrainCycles = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  req_t                in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rsp_t                out_data_o;

  logic [NumDevW-1:0] model_num_devices;
  logic [ShiftW-1:0]  model_sector_shift;
  rsp_t               expected_chunks[$];
  bit                 in_burst;
  bit                 out_burst;
  int                 fail_count;
  int                 n_requests;
  int                 n_chunks;
  int                 n_errors;
  int                 n_settings;

  stripe_request_splitter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_expected(rsp_t c);
    expected_chunks = {expected_chunks, c};
  endfunction

  // Splits one request into its expected chunk transfers at stripe boundaries, or into one error transfer if overlong.
  function automatic void split_request(req_t r);
    longint unsigned off, len, ndev, shift, sec, blk_off, part, stripe, dev, doff, s0, s1;
    int   cnt;
    rsp_t c;
    off   = 64'(r.request_offset);
    len   = 64'(r.request_length);
    ndev  = (model_num_devices == 0) ? 64'(1) :
            (model_num_devices > MaxDevices) ? 64'(MaxDevices) : 64'(model_num_devices);
    shift = (model_sector_shift < ShiftMin) ? 64'(ShiftMin) :
            (model_sector_shift > ShiftMax) ? 64'(ShiftMax) : 64'(model_sector_shift);
    sec   = 64'd1 << shift;
    if (len == 0) return;
    if (len > 64'(MaxLen)) begin
      c          = '0;
      c.is_write = r.cmd;
      c.error    = 1'b1;
      c.last     = 1'b1;
      queue_expected(c);
      return;
    end
    cnt = 0;
    while (len > 0 && cnt < MaxChunks) begin
      blk_off = off % StripeBytes;
      part    = StripeBytes - blk_off;
      stripe  = off / StripeBytes;
      if (part > len) part = len;
      dev  = stripe % ndev;
      doff = (stripe / ndev) * StripeBytes + blk_off;
      s0   = doff >> shift;
      s1   = (doff + part + sec - 1) >> shift;
      len -= part;
      off += part;
      c.device_index  = dev[DevW-1:0];
      c.device_offset = doff[OffW-1:0];
      c.chunk_length  = part[ChunkW-1:0];
      c.sector_start  = s0[OffW-1:0];
      c.sector_count  = SecCntW'(s1 - s0);
      c.is_write      = r.cmd;
      c.error         = 1'b0;
      c.last          = (len == 0);
      queue_expected(c);
      cnt++;
    end
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgNumDevices) model_num_devices = data;
    else model_sector_shift = data[ShiftW-1:0];
  endtask

  task automatic set_geometry(logic [CfgDataW-1:0] ndev, logic [CfgDataW-1:0] shift);
    write_reg(CfgNumDevices, ndev);
    write_reg(CfgSectorShift, shift);
    n_settings++;
  endtask

  task automatic send_request(logic cmd, logic [OffW-1:0] off, logic [LenW-1:0] len);
    int   gap;
    bit   taken;
    req_t r;
    gap              = pick_gap(in_burst);
    r.cmd            = cmd;
    r.request_offset = off;
    r.request_length = len;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    split_request(r);
    n_requests++;
  endtask

  // Waits for every expected transfer, then for the block to finish any silent work.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_chunks.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [OffW-1:0] rand_offset();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return raw[OffW-1:0] & ~OffW'(StripeBytes - 1);
      1: return (raw[OffW-1:0] | OffW'(StripeBytes - 1)) - OffW'($urandom_range(0, 600));
      2: return OffW'(raw[19:0]);
      default: return raw[OffW-1:0];
    endcase
  endfunction

  function automatic logic [LenW-1:0] rand_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 5) return LenW'($urandom_range(int'(MaxLen) + 1, (1 << LenW) - 1));
    if (r < 10) return LenW'($urandom_range(int'(MaxLen) - 40000, int'(MaxLen)));
    if (r < 28) return LenW'($urandom_range(1, 16 * StripeBytes));
    if (r < 45) return LenW'($urandom_range(1, 1024));
    return LenW'($urandom_range(1, 3 * StripeBytes));
  endfunction

  task automatic test_reset_defaults();
    send_request(1'b0, 48'd8000, 19'd9000);
    send_request(1'b1, 48'h0000_1234_5677, 19'd700);
    send_request(1'b1, 48'hFFFF_FFFF_F000, 19'd12000);
    drain();
  endtask

  task automatic test_boundaries();
    set_geometry(9'd5, 9'd9);
    send_request(1'b0, 48'h0000_0000_1000, 19'd0);
    send_request(1'b1, 48'd0, 19'd1);
    send_request(1'b0, 48'd0, LenW'(StripeBytes));
    send_request(1'b1, 48'd1, LenW'(StripeBytes));
    send_request(1'b0, 48'd8191, 19'd1);
    send_request(1'b1, 48'd511, 19'd2);
    send_request(1'b0, 48'd0, MaxLen);
    send_request(1'b1, 48'd4095, MaxLen);
    send_request(1'b1, 48'd0, MaxLen + 19'd1);
    send_request(1'b0, '1, '1);
    send_request(1'b0, '1, 19'd20000);
    send_request(1'b1, 48'hFFFF_FFFF_E000, LenW'(StripeBytes));
    drain();
  endtask

  task automatic test_register_clamping();
    logic [CfgDataW-1:0] ndevs[5]  = '{9'd0, 9'd511, 9'd256, 9'd257, 9'd3};
    logic [CfgDataW-1:0] shifts[5] = '{9'd0, 9'd511, 9'd12, 9'd8, 9'd13};
    for (int i = 0; i < 5; i++) begin
      set_geometry(ndevs[i], shifts[i]);
      send_request(i[0], rand_offset(), LenW'(3 * StripeBytes + 100));
      send_request(~i[0], rand_offset(), LenW'($urandom_range(1, 5000)));
      drain();
    end
  endtask

  task automatic test_random_traffic();
    logic [CfgDataW-1:0] ndev, shift;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 4))
        0: ndev = 9'd1;
        1: ndev = 9'd256;
        2: ndev = CfgDataW'($urandom_range(0, 511));
        default: ndev = CfgDataW'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 3) == 0) shift = CfgDataW'($urandom_range(0, 511));
      else shift = {5'($urandom), 4'($urandom_range(9, 12))};
      set_geometry(ndev, shift);
      in_burst  = (phase % 3 == 1);
      out_burst = (phase % 3 == 2);
      for (int k = 0; k < 31; k++) begin
        send_request(1'($urandom), rand_offset(), rand_length());
      end
      drain();
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgNumDevices;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    in_data_i          = '0;
    model_num_devices  = 9'd1;
    model_sector_shift = 4'd9;
    in_burst           = 1'b0;
    out_burst          = 1'b0;
    fail_count         = 0;
    n_requests         = 0;
    n_chunks           = 0;
    n_errors           = 0;
    n_settings         = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_boundaries();
    test_register_clamping();
    test_random_traffic();
    $display("Sent %0d requests under %0d register settings.", n_requests, n_settings);
    $display("Checked %0d chunk transfers and %0d error transfers.", n_chunks, n_errors);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap(out_burst);
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    rsp_t got, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
        got = out_data_o;
        if (expected_chunks.size() == 0) begin
          $error("Unexpected result transfer: %0h", got);
          fail_count++;
        end else begin
          want = expected_chunks.pop_front();
          check_field("device_index", 64'(want.device_index), 64'(got.device_index));
          check_field("device_offset", 64'(want.device_offset), 64'(got.device_offset));
          check_field("chunk_length", 64'(want.chunk_length), 64'(got.chunk_length));
          check_field("sector_start", 64'(want.sector_start), 64'(got.sector_start));
          check_field("sector_count", 64'(want.sector_count), 64'(got.sector_count));
          check_field("is_write", 64'(want.is_write), 64'(got.is_write));
          check_field("error", 64'(want.error), 64'(got.error));
          check_field("last", 64'(want.last), 64'(got.last));
          if (want.error) n_errors++;
          else n_chunks++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d transfers still expected.", expected_chunks.size());
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/srs_pkg.sv
rtl/srs_ctrl.sv
rtl/srs_dp.sv
rtl/stripe_request_splitter_top.sv
tb/sv/stripe_request_splitter_top_tb.sv
